// ===== rtl/csg_pkg.sv =====
// csg_pkg: types, constants and control store for the circle span generator
// no dependencies

package csg_pkg;

   localparam int M_W    = 6;
   localparam int R_W    = 6;
   localparam int Y_W    = 7;
   localparam int T_W    = 14;
   localparam int STEP_W = 3;
   localparam int BIT_W  = 3;

   localparam logic [7:0] TERM_CODE = 8'h80;

   typedef logic [STEP_W-1:0] step_type;

   typedef enum logic [2:0] {
      UOP_NOP,
      UOP_LOAD,
      UOP_TSQ,
      UOP_TSUB,
      UOP_MCLR,
      UOP_TRY,
      UOP_EMIT,
      UOP_TERM
   } uop_type;

   typedef enum logic [2:0] {
      COND_NEXT,
      COND_ALWAYS,
      COND_NO_START,
      COND_BIT_LEFT,
      COND_ROW_LEFT
   } cond_type;

   typedef struct packed {
      uop_type  op;
      cond_type cond;
      step_type target;
   } ucode_word_type;

   localparam step_type STEP_IDLE = 3'd0;
   localparam step_type STEP_TSQ  = 3'd1;
   localparam step_type STEP_TSUB = 3'd2;
   localparam step_type STEP_MCLR = 3'd3;
   localparam step_type STEP_TRY  = 3'd4;
   localparam step_type STEP_EMIT = 3'd5;
   localparam step_type STEP_ROW  = 3'd6;
   localparam step_type STEP_TERM = 3'd7;

   function automatic ucode_word_type ucode_rom(input step_type step);
      ucode_word_type w;
      unique case (step)
         STEP_IDLE: w = '{UOP_LOAD, COND_NO_START, STEP_IDLE};
         STEP_TSQ:  w = '{UOP_TSQ,  COND_NEXT,     STEP_IDLE};
         STEP_TSUB: w = '{UOP_TSUB, COND_NEXT,     STEP_IDLE};
         STEP_MCLR: w = '{UOP_MCLR, COND_NEXT,     STEP_IDLE};
         STEP_TRY:  w = '{UOP_TRY,  COND_BIT_LEFT, STEP_TRY};
         STEP_EMIT: w = '{UOP_EMIT, COND_NEXT,     STEP_IDLE};
         STEP_ROW:  w = '{UOP_NOP,  COND_ROW_LEFT, STEP_TSQ};
         STEP_TERM: w = '{UOP_TERM, COND_ALWAYS,   STEP_IDLE};
         default:   w = '{UOP_NOP,  COND_ALWAYS,   STEP_IDLE};
      endcase
      return w;
   endfunction

endpackage

// ===== rtl/circle_span_generator.sv =====
// circle_span_generator: spans of a filled disc from a microcoded sequencer
// depends on csg_pkg (control store, types, constants)
//
// usage:
//   a transaction is taken when start is high and busy is low; req_radius is
//   sampled then and clamped to 1..MAX_RADIUS
//   the block returns 2r-1 spans, top row first, then one terminator with
//   rsp_last high and -128 in the other fields; each result is on the rsp_
//   ports for one cycle, marked by rsp_valid, and the receiver cannot stall
//   each span runs the steps TSQ, TSUB, MCLR, the six-step bitwise
//   half-width search (TRY), EMIT and ROW, and is registered out from its
//   EMIT step; busy rises after the accept and stays high until the
//   terminator, which follows the ROW and TERM steps after the last span
//   one transaction at a time; busy falls in the cycle the terminator shows,
//   so the next transaction may be taken in that cycle
//   reset: synchronous, clears the step counter and the result strobe; no
//   clearing pass, the block is ready right after reset
module circle_span_generator #(
   parameter int MAX_RADIUS = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [7:0] req_radius,
   output logic       rsp_valid,
   output logic [7:0] rsp_start_offset,
   output logic [7:0] rsp_row_step,
   output logic [7:0] rsp_run_length,
   output logic       rsp_last
);
   import csg_pkg::*;

   localparam logic [7:0] MAX_R8 = 8'(MAX_RADIUS);

   step_type       step_ff, step_in;
   ucode_word_type uw;

   logic [R_W-1:0]   r_ff, r_in;
   logic [Y_W-1:0]   y_ff, y_in;
   logic [T_W-1:0]   t_ff, t_in;
   logic [M_W-1:0]   m_ff, m_in;
   logic [M_W-1:0]   prev_ff, prev_in;
   logic [BIT_W-1:0] bit_ff, bit_in;
   logic             first_ff, first_in;

   logic       valid_ff, valid_in;
   logic [7:0] start_ff, start_in;
   logic [7:0] row_ff, row_in;
   logic [7:0] run_ff, run_in;
   logic       last_ff, last_in;

   logic             accept;
   logic [7:0]       radius_clamped;
   logic [Y_W-1:0]   d;
   logic [T_W-1:0]   d_sq;
   logic [M_W-1:0]   y_abs;
   logic [2*M_W-1:0] y_sq;
   logic [M_W-1:0]   cand;
   logic [2*M_W-1:0] cand_sq;
   logic [T_W-1:0]   cand_sq4;
   logic             jump;

   assign uw     = ucode_rom(step_ff);
   assign busy   = (step_ff != STEP_IDLE);
   assign accept = start && !busy;

   always_comb begin
      if (req_radius > MAX_R8) begin
         radius_clamped = MAX_R8;
      end else if (req_radius == 8'd0) begin
         radius_clamped = 8'd1;
      end else begin
         radius_clamped = req_radius;
      end
   end

   // datapath operands
   assign d        = {r_ff, 1'b0} - Y_W'(1);
   assign d_sq     = T_W'(d) * T_W'(d);
   assign y_abs    = y_ff[Y_W-1] ? M_W'(-y_ff) : M_W'(y_ff);
   assign y_sq     = y_abs * y_abs;
   assign cand     = m_ff | (M_W'(1) << bit_ff);
   assign cand_sq  = cand * cand;
   assign cand_sq4 = {cand_sq, 2'b00};

   // sequencer
   always_comb begin
      unique case (uw.cond)
         COND_NEXT:     jump = 1'b0;
         COND_ALWAYS:   jump = 1'b1;
         COND_NO_START: jump = !start;
         COND_BIT_LEFT: jump = (bit_ff != '0);
         COND_ROW_LEFT: jump = ($signed(y_ff) < $signed({1'b0, r_ff}));
         default:       jump = 1'b1;
      endcase
      step_in = jump ? uw.target : step_ff + STEP_W'(1);
   end

   always_comb begin
      r_in     = r_ff;
      y_in     = y_ff;
      t_in     = t_ff;
      m_in     = m_ff;
      prev_in  = prev_ff;
      bit_in   = bit_ff;
      first_in = first_ff;
      valid_in = 1'b0;
      start_in = start_ff;
      row_in   = row_ff;
      run_in   = run_ff;
      last_in  = last_ff;
      unique case (uw.op)
         UOP_NOP: begin
         end
         UOP_LOAD: begin
            if (accept) begin
               r_in     = R_W'(radius_clamped);
               y_in     = Y_W'(1) - Y_W'(radius_clamped);
               first_in = 1'b1;
            end
         end
         UOP_TSQ: begin
            t_in = d_sq;
         end
         UOP_TSUB: begin
            t_in = t_ff - {y_sq, 2'b00};
         end
         UOP_MCLR: begin
            m_in   = '0;
            bit_in = BIT_W'(M_W - 1);
         end
         UOP_TRY: begin
            if (cand_sq4 < t_ff) begin
               m_in = cand;
            end
            bit_in = bit_ff - BIT_W'(1);
         end
         UOP_EMIT: begin
            valid_in = 1'b1;
            last_in  = 1'b0;
            run_in   = {1'b0, m_ff, 1'b1};
            if (first_ff) begin
               start_in = 8'd0 - 8'(m_ff);
               row_in   = 8'(signed'(y_ff));
            end else begin
               start_in = 8'd0 - (8'(prev_ff) + 8'(m_ff));
               row_in   = 8'd1;
            end
            prev_in  = m_ff + M_W'(1);
            first_in = 1'b0;
            y_in     = y_ff + Y_W'(1);
         end
         UOP_TERM: begin
            valid_in = 1'b1;
            last_in  = 1'b1;
            start_in = TERM_CODE;
            row_in   = TERM_CODE;
            run_in   = TERM_CODE;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= STEP_IDLE;
         valid_ff <= 1'b0;
      end else begin
         step_ff  <= step_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      r_ff     <= r_in;
      y_ff     <= y_in;
      t_ff     <= t_in;
      m_ff     <= m_in;
      prev_ff  <= prev_in;
      bit_ff   <= bit_in;
      first_ff <= first_in;
      start_ff <= start_in;
      row_ff   <= row_in;
      run_ff   <= run_in;
      last_ff  <= last_in;
   end

   assign rsp_valid        = valid_ff;
   assign rsp_start_offset = start_ff;
   assign rsp_row_step     = row_ff;
   assign rsp_run_length   = run_ff;
   assign rsp_last         = last_ff;

   // checks
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("busy did not rise after accepted transaction");

   a_term_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |-> !busy)
      else $error("terminator shown while sequencer still busy");

   a_span_odd: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |-> (rsp_run_length[0] && !rsp_run_length[7]))
      else $error("span length not positive odd");

   a_result_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |-> busy)
      else $error("span shown outside a transaction");

endmodule

// ===== verif/circle_span_generator_tb.sv =====
// circle_span_generator_tb: self-checking testbench for the circle span generator
// drives radius commands, predicts every span and terminator, checks each result in order
// depends on csg_pkg and circle_span_generator

module circle_span_generator_tb;

   import csg_pkg::TERM_CODE;

   localparam int MAX_RADIUS   = 32;
   localparam int RANDOM_CMDS  = 216;
   localparam int QUIET_TAIL   = 30;
   localparam int SETTLE_WAIT  = 40;
   localparam int CYCLE_LIMIT  = 1000000;

   typedef struct packed {
      logic signed [7:0] start_offset;
      logic signed [7:0] row_step;
      logic signed [7:0] run_length;
      logic              last;
   } span_t;

   typedef struct packed {
      logic [7:0] radius;
      logic       drain_first;
   } disc_cmd_t;

   logic       clock;
   logic       reset = 1'b1;
   logic       start = 1'b0;
   logic [7:0] req_radius = 8'd0;
   logic       busy;
   logic       rsp_valid;
   logic [7:0] rsp_start_offset;
   logic [7:0] rsp_row_step;
   logic [7:0] rsp_run_length;
   logic       rsp_last;

   disc_cmd_t  cmd_q[$];
   span_t      span_q[$];
   int         num_cmds   = 0;
   int         cmds_sent  = 0;
   int         spans_due  = 0;
   int         spans_seen = 0;
   int         errors     = 0;
   int         cycles     = 0;
   int         gap_left   = 0;
   bit         gap_idle_only = 1'b0;
   bit         idle_on    = 1'b1;

   circle_span_generator #(
      .MAX_RADIUS(MAX_RADIUS)
   ) u_top (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_radius      (req_radius),
      .rsp_valid       (rsp_valid),
      .rsp_start_offset(rsp_start_offset),
      .rsp_row_step    (rsp_row_step),
      .rsp_run_length  (rsp_run_length),
      .rsp_last        (rsp_last)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // expected spans of a clamped disc, top row first, then the terminator
   task automatic predict_spans(input logic [7:0] radius);
      int    r;
      int    y;
      int    m;
      int    prev_end;
      int    bound;
      span_t s;
      r = radius;
      if (r > MAX_RADIUS)
         r = MAX_RADIUS;
      if (r < 1)
         r = 1;
      prev_end = 0;
      for (y = -r + 1; y < r; y++) begin
         bound = (2 * r - 1) * (2 * r - 1) - 4 * y * y;
         m = 0;
         while (4 * (m + 1) * (m + 1) < bound)
            m++;
         if (y == -r + 1) begin
            s.start_offset = 8'(-m);
            s.row_step     = 8'(y);
         end else begin
            s.start_offset = 8'(-prev_end - m);
            s.row_step     = 8'sd1;
         end
         s.run_length = 8'(2 * m + 1);
         s.last       = 1'b0;
         span_q.push_back(s);
         prev_end = m + 1;
      end
      s.start_offset = TERM_CODE;
      s.row_step     = TERM_CODE;
      s.run_length   = TERM_CODE;
      s.last         = 1'b1;
      span_q.push_back(s);
      spans_due += 2 * r;
   endtask

   // command driver
   always @(posedge clock) begin
      logic       nxt_start;
      logic [7:0] nxt_radius;
      nxt_start  = start;
      nxt_radius = req_radius;
      if (reset) begin
         nxt_start = 1'b0;
         gap_left  = 0;
      end else begin
         if (start && !busy) begin
            predict_spans(req_radius);
            void'(cmd_q.pop_front());
            cmds_sent++;
            nxt_start = 1'b0;
            if (cmds_sent < num_cmds - QUIET_TAIL) begin
               if ($urandom_range(0, 7) == 0)
                  idle_on = !idle_on;
               if (idle_on && $urandom_range(0, 1) == 1) begin
                  gap_left      = $urandom_range(1, 16);
                  gap_idle_only = $urandom_range(0, 1);
               end
            end
         end
         if (!nxt_start) begin
            if (gap_left > 0) begin
               if (!gap_idle_only || !busy)
                  gap_left--;
            end else if (cmd_q.size() > 0 &&
                         (!cmd_q[0].drain_first || spans_due == spans_seen)) begin
               nxt_start  = 1'b1;
               nxt_radius = cmd_q[0].radius;
            end
         end
      end
      start      <= nxt_start;
      req_radius <= nxt_radius;
   end

   // result monitor
   always @(posedge clock) begin
      span_t got;
      span_t want;
      if (!reset && rsp_valid) begin
         got = '{rsp_start_offset, rsp_row_step, rsp_run_length, rsp_last};
         if (span_q.size() == 0) begin
            $error("unexpected result: start_offset %0d row_step %0d run_length %0d last %0d",
                   got.start_offset, got.row_step, got.run_length, got.last);
            errors++;
         end else begin
            want = span_q.pop_front();
            if (got.start_offset !== want.start_offset) begin
               $error("start_offset: expected %0d, got %0d", want.start_offset, got.start_offset);
               errors++;
            end
            if (got.row_step !== want.row_step) begin
               $error("row_step: expected %0d, got %0d", want.row_step, got.row_step);
               errors++;
            end
            if (got.run_length !== want.run_length) begin
               $error("run_length: expected %0d, got %0d", want.run_length, got.run_length);
               errors++;
            end
            if (got.last !== want.last) begin
               $error("last: expected %0d, got %0d", want.last, got.last);
               errors++;
            end
            spans_seen <= spans_seen + 1;
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("FAIL circle_span_generator");
         $finish;
      end
   end

   initial begin
      logic [7:0] corner_radii [14];
      disc_cmd_t  c;
      int         sel;
      corner_radii = '{8'd0, 8'd1, 8'd2, 8'd3, 8'd31, 8'd32, 8'd33, 8'd63,
                       8'd64, 8'd127, 8'd128, 8'd255, 8'd170, 8'd85};
      foreach (corner_radii[i]) begin
         c.radius      = corner_radii[i];
         c.drain_first = 1'b0;
         cmd_q.push_back(c);
      end
      for (int i = 0; i < RANDOM_CMDS; i++) begin
         sel = $urandom_range(0, 9);
         if (sel < 6)
            c.radius = 8'($urandom_range(0, 40));
         else if (sel < 8)
            c.radius = 8'($urandom_range(0, 3));
         else
            c.radius = 8'($urandom_range(0, 255));
         // hold off until the block has drained
         c.drain_first = (i == 0 || i == RANDOM_CMDS / 2);
         cmd_q.push_back(c);
      end
      num_cmds = cmd_q.size();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      do
         @(posedge clock);
      while (cmds_sent < num_cmds || spans_due != spans_seen);
      repeat (SETTLE_WAIT) @(posedge clock);
      if (errors == 0 && span_q.size() == 0)
         $display("PASS circle_span_generator");
      else
         $display("FAIL circle_span_generator");
      $finish;
   end

endmodule

// ===== circle_span_generator.f =====
rtl/csg_pkg.sv
rtl/circle_span_generator.sv
verif/circle_span_generator_tb.sv
